FILE: rtl/core/sasd_pkg.sv
package sasd_pkg;

    // Result kinds
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_PALETTE = 3'd1;
    localparam logic [2:0] KIND_PIXEL   = 3'd2;
    localparam logic [2:0] KIND_FEND    = 3'd3;
    localparam logic [2:0] KIND_NOFRAME = 3'd4;

    // Palette scaling: b*255/63 = 4*b + b/21, with b/21 = (b*391) >> 13 for b < 256
    localparam logic [8:0] PAL_RECIP = 9'd391;
    localparam int         PAL_SHIFT = 13;

    // One result beat as it travels through the queue
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] frame_number;
        logic [31:0] position;
        logic [15:0] value;
        logic        last;
    } sasd_item_t;

endpackage

FILE: rtl/core/sasd_front.sv
module sasd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          file_byte,
    output logic                push,
    output sasd_pkg::sasd_item_t item
);
    import sasd_pkg::*;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PALETTE = 3'd1;
    localparam logic [2:0] PH_OFFSETS = 3'd2;
    localparam logic [2:0] PH_FRAMES  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam logic [17:0] HDR_LAST    = 18'd15;
    localparam logic [17:0] PAL_FIRST   = 18'd192;
    localparam logic [17:0] PAL_LAST    = 18'd767;
    localparam logic [7:0]  COLOR_BASE  = 8'd64;
    localparam logic [7:0]  SKIP_MAX    = 8'd63;

    logic [2:0]  phase_reg, phase_next;
    logic [17:0] bc_reg, bc_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] ftotal_reg, ftotal_next;
    logic [15:0] fwidth_reg, fwidth_next;
    logic [15:0] fheight_reg, fheight_next;
    logic [31:0] ptotal_reg, ptotal_next;
    logic [32:0] ppos_reg, ppos_next;
    logic [15:0] fcount_reg, fcount_next;

    logic        push_c;
    sasd_item_t  item_c;
    logic [15:0] word;
    logic [17:0] off_end;
    logic [31:0] area;
    logic        fin;

    assign word    = {file_byte, low_reg};
    assign off_end = {ftotal_reg, 2'b00} + 18'd3;
    assign area    = 32'(fwidth_reg) * 32'(fheight_reg);
    assign fin     = ({1'b0, fcount_reg} + 17'd1) >= {1'b0, ftotal_reg};

    // Classify the byte and advance the parse state
    always_comb
    begin
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        low_next     = low_reg;
        ftotal_next  = ftotal_reg;
        fwidth_next  = fwidth_reg;
        fheight_next = fheight_reg;
        ptotal_next  = ptotal_reg;
        ppos_next    = ppos_reg;
        fcount_next  = fcount_reg;
        push_c       = 1'b0;
        item_c       = '0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (!bc_reg[0])
                begin
                    low_next = file_byte;
                end
                else
                begin
                    item_c.kind  = KIND_HEADER;
                    item_c.value = word;
                    case (bc_reg[3:1])
                        3'd0:
                        begin
                            push_c = 1'b1;
                            item_c.position = 32'd0;
                        end
                        3'd1:
                        begin
                            push_c = 1'b1;
                            ftotal_next = word;
                            item_c.position = 32'd1;
                        end
                        3'd2:
                        begin
                            push_c = 1'b1;
                            fwidth_next = word;
                            item_c.position = 32'd2;
                        end
                        3'd3:
                        begin
                            push_c = 1'b1;
                            fheight_next = word;
                            item_c.position = 32'd3;
                        end
                        3'd5:
                        begin
                            push_c = 1'b1;
                            item_c.position = 32'd4;
                        end
                        default:
                        begin
                            push_c = 1'b0;
                        end
                    endcase
                end
                if (bc_reg >= HDR_LAST)
                begin
                    bc_next     = '0;
                    ptotal_next = area;
                    phase_next  = PH_PALETTE;
                end
                else
                begin
                    bc_next = bc_reg + 18'd1;
                end
            end
            PH_PALETTE:
            begin
                if (bc_reg >= PAL_FIRST)
                begin
                    push_c          = 1'b1;
                    item_c.kind     = KIND_PALETTE;
                    item_c.position = 32'(bc_reg - PAL_FIRST);
                    item_c.value    = {8'd0, file_byte};
                end
                if (bc_reg >= PAL_LAST)
                begin
                    bc_next    = '0;
                    phase_next = PH_OFFSETS;
                end
                else
                begin
                    bc_next = bc_reg + 18'd1;
                end
            end
            PH_OFFSETS:
            begin
                if (bc_reg >= off_end)
                begin
                    bc_next = '0;
                    if (ftotal_reg == 16'd0)
                    begin
                        phase_next  = PH_DONE;
                        push_c      = 1'b1;
                        item_c.kind = KIND_NOFRAME;
                        item_c.last = 1'b1;
                    end
                    else
                    begin
                        phase_next  = PH_FRAMES;
                        ppos_next   = '0;
                        fcount_next = '0;
                    end
                end
                else
                begin
                    bc_next = bc_reg + 18'd1;
                end
            end
            PH_FRAMES:
            begin
                if (file_byte == 8'd0 || ppos_reg >= {1'b0, ptotal_reg})
                begin
                    push_c              = 1'b1;
                    item_c.kind         = KIND_FEND;
                    item_c.frame_number = fcount_reg;
                    item_c.last         = fin;
                    ppos_next           = '0;
                    if (fin)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        fcount_next = fcount_reg + 16'd1;
                    end
                end
                else if (file_byte > SKIP_MAX)
                begin
                    push_c              = 1'b1;
                    item_c.kind         = KIND_PIXEL;
                    item_c.frame_number = fcount_reg;
                    item_c.position     = ppos_reg[31:0];
                    item_c.value        = {8'd0, file_byte - COLOR_BASE};
                    ppos_next           = ppos_reg + 33'd1;
                end
                else
                begin
                    ppos_next = ppos_reg + 33'(file_byte);
                end
            end
            default:
            begin
                push_c = 1'b0;
            end
        endcase
    end

    assign push = fire & push_c;
    assign item = item_c;

    // Commit the parse state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            bc_reg      <= '0;
            low_reg     <= '0;
            ftotal_reg  <= '0;
            fwidth_reg  <= '0;
            fheight_reg <= '0;
            ptotal_reg  <= '0;
            ppos_reg    <= '0;
            fcount_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            low_reg     <= low_next;
            ftotal_reg  <= ftotal_next;
            fwidth_reg  <= fwidth_next;
            fheight_reg <= fheight_next;
            ptotal_reg  <= ptotal_next;
            ppos_reg    <= ppos_next;
            fcount_reg  <= fcount_next;
        end
    end

endmodule

FILE: rtl/core/sasd_queue.sv
module sasd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sasd_pkg::sasd_item_t push_item,
    output logic                can_push,
    input  logic                pop,
    output logic                not_empty,
    output sasd_pkg::sasd_item_t head_item
);
    import sasd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    sasd_item_t    slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign can_push  = cnt_reg != CNT_FULL;
    assign not_empty = cnt_reg != '0;
    assign head_item = slot_reg[rd_reg];

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/sasd_back.sv
module sasd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sasd_pkg::sasd_item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          kind,
    output logic [15:0]         frame_number,
    output logic [31:0]         position,
    output logic [15:0]         value,
    output logic                last
);
    import sasd_pkg::*;

    logic        ovalid_reg;
    sasd_item_t  obeat_reg;
    sasd_item_t  load_item;
    logic        load;
    logic [7:0]  comp;
    logic [16:0] recip_prod;
    logic [7:0]  scaled;
    logic [15:0] value_c;

    assign load = q_valid && (!ovalid_reg || out_ready);
    assign q_pop = load;

    // Scale a six-bit palette component to eight bits
    assign comp       = q_item.value[7:0];
    assign recip_prod = 17'(comp) * 17'(PAL_RECIP);
    assign scaled     = {comp[5:0], 2'b00} + 8'(recip_prod >> PAL_SHIFT);
    assign value_c    = (q_item.kind == KIND_PALETTE) ? {8'd0, scaled} : q_item.value;

    // Swap in the scaled value
    always_comb
    begin
        load_item       = q_item;
        load_item.value = value_c;
    end

    // Hold the output beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obeat_reg <= load_item;
        end
    end

    assign out_valid    = ovalid_reg;
    assign kind         = obeat_reg.kind;
    assign frame_number = obeat_reg.frame_number;
    assign position     = obeat_reg.position;
    assign value        = obeat_reg.value;
    assign last         = obeat_reg.last;

endmodule

FILE: rtl/core/snp_animation_stream_decoder.sv
// Animation stream decoder: takes the file one byte per beat and emits one result beat per
// reported item (header field, scaled palette component for entries 64..255, pixel write,
// frame end, or a no-frames marker), with last set on the final result of the stream.
// A byte is taken every cycle while the result queue has room; the front parser updates its
// counters on each accepted byte, so the sustained rate is one byte per clock while the queue
// has room. A result is written into the queue when its byte is accepted, then loaded into the
// output register once that register is empty or being taken; the QUEUE_DEPTH-entry queue plus
// the output register absorb output stalls before the input side stops.
module snp_animation_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] frame_number,
    output logic [31:0] position,
    output logic [15:0] value,
    output logic        last
);
    import sasd_pkg::*;

    logic       fire;
    logic       push;
    logic       can_push;
    logic       q_valid;
    logic       q_pop;
    sasd_item_t push_item;
    sasd_item_t head_item;

    assign in_ready = can_push;
    assign fire     = in_valid && can_push;

    sasd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .file_byte (file_byte),
        .push      (push),
        .item      (push_item)
    );

    sasd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .can_push  (can_push),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    sasd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .frame_number (frame_number),
        .position     (position),
        .value        (value),
        .last         (last)
    );

endmodule

FILE: test/snp_animation_stream_decoder_tb.sv
module snp_animation_stream_decoder_tb;

    import sasd_pkg::*;

    // Header field ids as reported in the position field
    localparam logic [31:0] FLD_VERSION = 32'd0;
    localparam logic [31:0] FLD_FRAMES  = 32'd1;
    localparam logic [31:0] FLD_WIDTH   = 32'd2;
    localparam logic [31:0] FLD_HEIGHT  = 32'd3;
    localparam logic [31:0] FLD_DELAY   = 32'd4;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_PALETTE,
        ST_OFFSETS,
        ST_FRAMES,
        ST_DONE
    } parse_state_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct {
        logic [15:0] word;
        bit          reported;
        logic [31:0] field;
    } hdr_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  file_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [15:0] frame_number;
    logic [31:0] position;
    logic [15:0] value;
    logic        last;

    // Decoder state mirrored by the testbench
    parse_state_t st = ST_HEADER;
    logic [17:0]  byte_cnt = '0;
    logic [7:0]   low_hold = '0;
    logic [15:0]  n_frames = '0;
    logic [15:0]  img_w = '0;
    logic [15:0]  img_h = '0;
    logic [31:0]  img_pixels = '0;
    logic [32:0]  pix_pos = '0;
    logic [15:0]  frame_idx = '0;

    sasd_item_t pending_results[$];
    int         mismatches = 0;
    int         burst_left = 1;
    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_left = 0;

    // Palette components placed first in the reported range
    logic [7:0] pal_edge [6] = '{8'd0, 8'd63, 8'd64, 8'd255, 8'd21, 8'd42};

    snp_animation_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .file_byte    (file_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .frame_number (frame_number),
        .position     (position),
        .value        (value),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // Advance the decoder state by one file byte and return the result it causes
    task automatic decode_byte(input logic [7:0] b, output bit has, output sasd_item_t res);
        logic [15:0] w;
        logic [31:0] scaled;
        logic [31:0] tbl_end;
        bit          fin;
        has = 1'b0;
        res = '0;
        case (st)
            ST_HEADER:
            begin
                if (!byte_cnt[0])
                    low_hold = b;
                else
                begin
                    w = {b, low_hold};
                    has = 1'b1;
                    res.kind = KIND_HEADER;
                    res.value = w;
                    case (byte_cnt[3:1])
                        3'd0: res.position = FLD_VERSION;
                        3'd1:
                        begin
                            n_frames = w;
                            res.position = FLD_FRAMES;
                        end
                        3'd2:
                        begin
                            img_w = w;
                            res.position = FLD_WIDTH;
                        end
                        3'd3:
                        begin
                            img_h = w;
                            res.position = FLD_HEIGHT;
                        end
                        3'd5: res.position = FLD_DELAY;
                        default: has = 1'b0;
                    endcase
                end
                if (byte_cnt >= 18'd15)
                begin
                    byte_cnt = '0;
                    img_pixels = 32'(img_w) * 32'(img_h);
                    st = ST_PALETTE;
                end
                else
                    byte_cnt = byte_cnt + 18'd1;
            end
            ST_PALETTE:
            begin
                // entries 0..63 are read but not reported
                if (byte_cnt >= 18'd192)
                begin
                    scaled = (32'(b) * 32'd255) / 32'd63;
                    has = 1'b1;
                    res.kind = KIND_PALETTE;
                    res.position = 32'(byte_cnt) - 32'd192;
                    res.value = {8'h00, scaled[7:0]};
                end
                if (byte_cnt >= 18'd767)
                begin
                    byte_cnt = '0;
                    st = ST_OFFSETS;
                end
                else
                    byte_cnt = byte_cnt + 18'd1;
            end
            ST_OFFSETS:
            begin
                tbl_end = {14'b0, n_frames, 2'b00} + 32'd3;
                if (32'(byte_cnt) >= tbl_end)
                begin
                    byte_cnt = '0;
                    if (n_frames == 16'd0)
                    begin
                        st = ST_DONE;
                        has = 1'b1;
                        res.kind = KIND_NOFRAME;
                        res.last = 1'b1;
                    end
                    else
                    begin
                        st = ST_FRAMES;
                        pix_pos = '0;
                        frame_idx = '0;
                    end
                end
                else
                    byte_cnt = byte_cnt + 18'd1;
            end
            ST_FRAMES:
            begin
                if (b == 8'd0 || pix_pos >= {1'b0, img_pixels})
                begin
                    fin = (32'(frame_idx) + 32'd1 >= 32'(n_frames));
                    has = 1'b1;
                    res.kind = KIND_FEND;
                    res.frame_number = frame_idx;
                    res.last = fin;
                    pix_pos = '0;
                    if (fin)
                        st = ST_DONE;
                    else
                        frame_idx = frame_idx + 16'd1;
                end
                else if (b > 8'd63)
                begin
                    has = 1'b1;
                    res.kind = KIND_PIXEL;
                    res.frame_number = frame_idx;
                    res.position = pix_pos[31:0];
                    res.value = 16'(b - 8'd64);
                    pix_pos = pix_pos + 33'd1;
                end
                else
                    pix_pos = pix_pos + 33'(b);
            end
            default: ;
        endcase
    endtask

    // Send one beat, then log its expected result and maybe open a gap
    task automatic put_byte(input logic [7:0] b, input bit typed, input bit typed_has,
                            input sasd_item_t typed_res);
        bit         has;
        sasd_item_t res;
        file_byte <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, has, res);
        if (typed)
        begin
            has = typed_has;
            res = typed_res;
        end
        if (has)
            pending_results.push_back(res);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
        end
    endtask

    // Receiver stall pattern: switch between modes every so often
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (rx_left % 3 == 0);
        endcase
    end

    // Check each output beat against the oldest expected result
    sasd_item_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing expected, kind", 32'(kind), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (frame_number !== want.frame_number)
                    report_mismatch("frame_number", 32'(frame_number), 32'(want.frame_number));
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
                if (value !== want.value)
                    report_mismatch("value", 32'(value), 32'(want.value));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        hdr_word_t   hdr_table [8];
        logic [15:0] frames_w;
        logic [15:0] width_w;
        logic [15:0] height_w;
        sasd_item_t  typed;
        logic [7:0]  b;
        int          geo;
        int          r;

        // Pick the image geometry: mostly small, sometimes empty or the largest
        geo = $urandom_range(0, 9);
        frames_w = 16'($urandom_range(4, 12));
        width_w = 16'($urandom_range(1, 12));
        height_w = 16'($urandom_range(1, 10));
        if (geo == 0)
            height_w = 16'd0;
        else if (geo == 1)
        begin
            width_w = 16'hFFFF;
            height_w = 16'hFFFF;
        end

        hdr_table = '{
            '{16'hFFFF,  1'b1, FLD_VERSION},
            '{frames_w,  1'b1, FLD_FRAMES},
            '{width_w,   1'b1, FLD_WIDTH},
            '{height_w,  1'b1, FLD_HEIGHT},
            '{16'h0000,  1'b0, 32'd0},
            '{16'h8001,  1'b1, FLD_DELAY},
            '{16'hA55A,  1'b0, 32'd0},
            '{16'h5AA5,  1'b0, 32'd0}
        };

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Header: each word low byte first, reported words checked as typed
        for (int i = 0; i < 8; i++)
        begin
            typed = '0;
            typed.kind = KIND_HEADER;
            typed.position = hdr_table[i].field;
            typed.value = hdr_table[i].word;
            put_byte(hdr_table[i].word[7:0], 1'b1, 1'b0, typed);
            put_byte(hdr_table[i].word[15:8], 1'b1, hdr_table[i].reported, typed);
        end

        // Palette: edge components first in the reported range, rest random
        for (int k = 0; k < 768; k++)
        begin
            if (k >= 192 && k < 198)
                b = pal_edge[k - 192];
            else
                b = 8'($urandom_range(0, 255));
            put_byte(b, 1'b0, 1'b0, '0);
        end

        // Offset table and frames until the last frame ends
        while (st != ST_DONE)
        begin
            b = 8'($urandom_range(0, 255));
            if (st == ST_FRAMES && pix_pos < {1'b0, img_pixels})
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    b = 8'd0;
                else if (r < 25)
                    b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 63))
                                                    : 8'($urandom_range(1, 3));
                else
                    b = 8'($urandom_range(64, 255));
            end
            put_byte(b, 1'b0, 1'b0, '0);
        end

        // Trailing bytes after the stream is done: drop silently
        repeat (24)
            put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: snp_animation_stream_decoder.f
rtl/core/sasd_pkg.sv
rtl/core/sasd_front.sv
rtl/core/sasd_queue.sv
rtl/core/sasd_back.sv
rtl/core/snp_animation_stream_decoder.sv
test/snp_animation_stream_decoder_tb.sv
